>>> src/gmfd_pkg.sv
// Package for the forward-difference gradient magnitude block.
// Holds field widths, register indexes, job codes and the controller/datapath
// command and status types. No dependencies.
`default_nettype none

package gmfd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int RESET_WIDTH       = 1024;
   localparam int RESET_HEIGHT      = 1024;
   localparam int ROW_LIMIT         = 4096;

   localparam int PIX_W       = 8;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 12;
   localparam int IMG_W_FIELD = 11;
   localparam int IMG_H_FIELD = 13;
   localparam int CSR_W       = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int SUM_W       = 17;
   localparam int ROOT_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef logic [1:0] job_type;

   localparam job_type JOB_ABOVE = 2'd0;
   localparam job_type JOB_LEFT  = 2'd1;
   localparam job_type JOB_SELF  = 2'd2;
   localparam job_type JOB_NONE  = 2'd3;

   typedef struct packed {
      logic    take_pixel;
      logic    rd_next;
      logic    cap_a;
      logic    cap_b;
      logic    load_job;
      job_type job;
      logic    square;
      logic    out_load;
      logic    wr_line;
   } gmfd_cmd_type;

   typedef struct packed {
      logic y_ge1;
      logic last_row;
      logic x_ge1;
      logic x_last;
      logic root_busy;
      logic out_free;
   } gmfd_status_type;

endpackage

`default_nettype wire

>>> src/gmfd_if.sv
// Handshake interfaces for the pixel input channel and the gradient result
// channel. Depends on gmfd_pkg for the field widths.
`default_nettype none

interface gmfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [gmfd_pkg::PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface gmfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gmfd_pkg::PIX_W-1:0]  grad_h;
   logic [gmfd_pkg::PIX_W-1:0]  grad_v;
   logic [gmfd_pkg::ROOT_W-1:0] magnitude;
   logic [gmfd_pkg::COL_W-1:0]  col;
   logic [gmfd_pkg::ROW_W-1:0]  row;
   logic                        last_of_frame;

   modport source (output valid, output grad_h, output grad_v, output magnitude,
                   output col, output row, output last_of_frame, input ready);
   modport sink (input valid, input grad_h, input grad_v, input magnitude,
                 input col, input row, input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> src/gmfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gmfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/gmfd_isqrt.sv
// Iterative integer square root, two root bits per cycle, saturating at 255.
// Depends on gmfd_pkg for the operand and root widths.
`default_nettype none

module gmfd_isqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [gmfd_pkg::SUM_W-1:0]  operand,
   output logic                             busy,
   output logic      [gmfd_pkg::ROOT_W-1:0] root
);
   import gmfd_pkg::*;

   localparam int REM_W = 11;
   localparam int SH_W  = SUM_W - 1;

   logic              busy_ff, busy_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [ROOT_W-1:0] q_ff, q_in;
   logic [REM_W-1:0]  r_ff, r_in;
   logic              sat_ff, sat_in;

   always_comb begin
      logic [REM_W-1:0]  r;
      logic [REM_W-1:0]  t;
      logic [ROOT_W-1:0] q;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      sat_in  = sat_ff;
      r       = r_ff;
      q       = q_ff;
      t       = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = operand[SH_W-1:0];
         q_in    = '0;
         r_in    = '0;
         sat_in  = operand[SUM_W-1];
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            r = REM_W'({r, sh_ff[SH_W-1-2*i -: 2]});
            t = REM_W'({q, 2'b01});
            if (r >= t) begin
               r = r - t;
               q = ROOT_W'({q, 1'b1});
            end else begin
               q = ROOT_W'({q, 1'b0});
            end
         end
         r_in   = r;
         q_in   = q;
         sh_in  = SH_W'({sh_ff, 4'b0000});
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      sat_ff <= sat_in;
   end

   assign busy = busy_ff;
   assign root = sat_ff ? '1 : q_ff;

endmodule

`default_nettype wire

>>> src/gmfd_dp.sv
// Datapath: frame counters, configuration registers, line store, gradient
// selection, squaring, square root unit and the result register.
// Depends on gmfd_pkg, gmfd_ram and gmfd_isqrt.
`default_nettype none

module gmfd_dp #(
   parameter int MAX_WIDTH = gmfd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gmfd_pkg::gmfd_cmd_type             cmd,
   output gmfd_pkg::gmfd_status_type               status,
   input  wire logic [gmfd_pkg::PIX_W-1:0]         pixel,
   input  wire logic                               csr_we,
   input  wire logic [gmfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gmfd_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic      [gmfd_pkg::PIX_W-1:0]         rsp_grad_h,
   output logic      [gmfd_pkg::PIX_W-1:0]         rsp_grad_v,
   output logic      [gmfd_pkg::ROOT_W-1:0]        rsp_magnitude,
   output logic      [gmfd_pkg::COL_W-1:0]         rsp_col,
   output logic      [gmfd_pkg::ROW_W-1:0]         rsp_row,
   output logic                                    rsp_last_of_frame
);
   import gmfd_pkg::*;

   localparam int AW          = $clog2(MAX_WIDTH);
   localparam int RESET_WLAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic [AW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PIX_W-1:0]  prev_ff, prev_in;
   logic [AW-1:0]     wlast_ff, wlast_in;
   logic [ROW_W-1:0]  hlast_ff, hlast_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [PIX_W-1:0]  a_ff, a_in;
   logic [PIX_W-1:0]  b_ff, b_in;
   logic [PIX_W-1:0]  gh_ff, gh_in;
   logic [PIX_W-1:0]  gv_ff, gv_in;
   logic [AW-1:0]     jcol_ff, jcol_in;
   logic [ROW_W-1:0]  jrow_ff, jrow_in;
   logic              jlast_ff, jlast_in;
   logic              ovalid_ff, ovalid_in;
   logic [PIX_W-1:0]  ogh_ff, ogh_in;
   logic [PIX_W-1:0]  ogv_ff, ogv_in;
   logic [ROOT_W-1:0] omag_ff, omag_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [ROW_W-1:0]  orow_ff, orow_in;
   logic              olast_ff, olast_in;

   logic              x_last;
   logic              last_row;
   logic [AW-1:0]     raddr;
   logic [PIX_W-1:0]  rdata;
   logic [SUM_W-1:0]  sum_sq;
   logic              root_busy;
   logic [ROOT_W-1:0] root;

   assign x_last   = (col_ff == wlast_ff);
   assign last_row = (row_ff == hlast_ff);
   assign raddr    = cmd.rd_next ? col_ff + AW'(1) : col_ff;
   assign sum_sq   = SUM_W'(gh_ff) * SUM_W'(gh_ff) + SUM_W'(gv_ff) * SUM_W'(gv_ff);

   gmfd_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line (
      .clock(clock),
      .we   (cmd.wr_line),
      .waddr(col_ff),
      .wdata(pix_ff),
      .raddr(raddr),
      .rdata(rdata)
   );

   gmfd_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.square),
      .operand(sum_sq),
      .busy   (root_busy),
      .root   (root)
   );

   always_comb begin
      logic [31:0] wval;
      logic [31:0] hval;
      col_in    = col_ff;
      row_in    = row_ff;
      prev_in   = prev_ff;
      wlast_in  = wlast_ff;
      hlast_in  = hlast_ff;
      pix_in    = pix_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      gh_in     = gh_ff;
      gv_in     = gv_ff;
      jcol_in   = jcol_ff;
      jrow_in   = jrow_ff;
      jlast_in  = jlast_ff;
      ovalid_in = ovalid_ff;
      ogh_in    = ogh_ff;
      ogv_in    = ogv_ff;
      omag_in   = omag_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      olast_in  = olast_ff;
      wval      = 32'(csr_wdata[IMG_W_FIELD-1:0]);
      hval      = 32'(csr_wdata[IMG_H_FIELD-1:0]);

      if (wval == 32'd0) begin
         wval = 32'd1;
      end else if (wval > 32'(MAX_WIDTH)) begin
         wval = 32'(MAX_WIDTH);
      end
      if (hval == 32'd0) begin
         hval = 32'd1;
      end else if (hval > 32'(ROW_LIMIT)) begin
         hval = 32'(ROW_LIMIT);
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               wlast_in = AW'(wval - 32'd1);
            end
            CSR_IMAGE_HEIGHT: begin
               hlast_in = ROW_W'(hval - 32'd1);
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         prev_in = '0;
      end

      if (cmd.take_pixel) begin
         pix_in = pixel;
      end
      if (cmd.cap_a) begin
         a_in = rdata;
      end
      if (cmd.cap_b) begin
         b_in = rdata;
      end

      if (cmd.load_job) begin
         unique case (cmd.job)
            JOB_ABOVE: begin
               gh_in    = x_last ? a_ff : abs_diff(b_ff, a_ff);
               gv_in    = abs_diff(pix_ff, a_ff);
               jcol_in  = col_ff;
               jrow_in  = row_ff - ROW_W'(1);
               jlast_in = 1'b0;
            end
            JOB_LEFT: begin
               gh_in    = abs_diff(pix_ff, prev_ff);
               gv_in    = prev_ff;
               jcol_in  = col_ff - AW'(1);
               jrow_in  = row_ff;
               jlast_in = 1'b0;
            end
            JOB_SELF: begin
               gh_in    = pix_ff;
               gv_in    = pix_ff;
               jcol_in  = col_ff;
               jrow_in  = row_ff;
               jlast_in = 1'b1;
            end
            JOB_NONE: begin
               jlast_in = 1'b0;
            end
         endcase
      end

      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end
      if (cmd.out_load) begin
         ovalid_in = 1'b1;
         ogh_in    = gh_ff;
         ogv_in    = gv_ff;
         omag_in   = root;
         ocol_in   = COL_W'(jcol_ff);
         orow_in   = jrow_ff;
         olast_in  = jlast_ff;
      end

      if (cmd.wr_line) begin
         prev_in = pix_ff;
         if (x_last) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         prev_ff   <= '0;
         wlast_ff  <= AW'(RESET_WLAST);
         hlast_ff  <= ROW_W'(RESET_HEIGHT - 1);
         ovalid_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         prev_ff   <= prev_in;
         wlast_ff  <= wlast_in;
         hlast_ff  <= hlast_in;
         ovalid_ff <= ovalid_in;
      end
      pix_ff   <= pix_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      gh_ff    <= gh_in;
      gv_ff    <= gv_in;
      jcol_ff  <= jcol_in;
      jrow_ff  <= jrow_in;
      jlast_ff <= jlast_in;
      ogh_ff   <= ogh_in;
      ogv_ff   <= ogv_in;
      omag_ff  <= omag_in;
      ocol_ff  <= ocol_in;
      orow_ff  <= orow_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      status           = '0;
      status.y_ge1     = (row_ff != '0);
      status.last_row  = last_row;
      status.x_ge1     = (col_ff != '0);
      status.x_last    = x_last;
      status.root_busy = root_busy;
      status.out_free  = !ovalid_ff || rsp_ready;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_grad_h        = ogh_ff;
   assign rsp_grad_v        = ogv_ff;
   assign rsp_magnitude     = omag_ff;
   assign rsp_col           = ocol_ff;
   assign rsp_row           = orow_ff;
   assign rsp_last_of_frame = olast_ff;

endmodule

`default_nettype wire

>>> src/gmfd_ctrl.sv
// Controller state machine: sequences line store reads, the up to three
// results of one item, and the line store write. Depends on gmfd_pkg.
`default_nettype none

module gmfd_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire gmfd_pkg::gmfd_status_type status,
   output gmfd_pkg::gmfd_cmd_type         cmd
);
   import gmfd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDA  = 3'd1;
   localparam logic [2:0] S_RDB  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_SQ   = 3'd4;
   localparam logic [2:0] S_ROOT = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;
   localparam logic [2:0] S_WR   = 3'd7;

   logic [2:0] state_ff, state_in;
   job_type    job_ff, job_in;

   function automatic job_type succ(input job_type j);
      job_type n;
      n = JOB_NONE;
      unique case (j)
         JOB_ABOVE: n = JOB_LEFT;
         JOB_LEFT:  n = JOB_SELF;
         JOB_SELF:  n = JOB_NONE;
         JOB_NONE:  n = JOB_NONE;
      endcase
      return n;
   endfunction

   function automatic job_type first_from(input job_type start,
                                          input gmfd_status_type st);
      logic en_above;
      logic en_left;
      logic en_self;
      job_type j;
      en_above = st.y_ge1;
      en_left  = st.last_row && st.x_ge1;
      en_self  = st.last_row && st.x_last;
      priority if (start == JOB_ABOVE && en_above) begin
         j = JOB_ABOVE;
      end else if ((start == JOB_ABOVE || start == JOB_LEFT) && en_left) begin
         j = JOB_LEFT;
      end else if (start != JOB_NONE && en_self) begin
         j = JOB_SELF;
      end else begin
         j = JOB_NONE;
      end
      return j;
   endfunction

   always_comb begin
      job_type nj;
      state_in = state_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      nj       = JOB_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_pixel = 1'b1;
               if (status.y_ge1) begin
                  state_in = S_RDA;
               end else begin
                  nj       = first_from(JOB_ABOVE, status);
                  job_in   = nj;
                  state_in = (nj == JOB_NONE) ? S_WR : S_LOAD;
               end
            end
         end
         S_RDA: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_RDB;
         end
         S_RDB: begin
            cmd.cap_b = 1'b1;
            job_in    = first_from(JOB_ABOVE, status);
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_job = 1'b1;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.square = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (!status.root_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               nj           = first_from(succ(job_ff), status);
               job_in       = nj;
               state_in     = (nj == JOB_NONE) ? S_WR : S_LOAD;
            end
         end
         S_WR: begin
            cmd.wr_line = 1'b1;
            state_in    = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= JOB_NONE;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

>>> src/gradient_magnitude_forward_diff.sv
// Top level of the forward-difference gradient magnitude block.
// Depends on gmfd_pkg, gmfd_if, gmfd_ctrl and gmfd_dp.
//
// Pixels of an 8-bit grey image enter in raster order on req_bus. For every
// pixel the block returns on rsp_bus the absolute horizontal and vertical
// forward differences and the saturated floor square root of their squared
// sum, tagged with column, row and an end-of-frame flag. A result for row
// y-1 leaves when the pixel below it arrives; last-row results leave as soon
// as their right neighbor has arrived. Image size is set through the csr_
// write port; a write restarts the frame at column 0, row 0.
// Items are handled one at a time. An item that causes no result goes
// straight to the line store write. Otherwise, in rows after the first,
// the line store is read twice; each result is then selected, squared,
// put through the two-bits-per-cycle square root and loaded into the output
// register, and the line store write ends the item.
// A finished result waits in the output register; when the receiver stalls,
// the next result of the same item waits for it, and the block takes no new
// item until all results of the current one are in the register.
// Reset clears the counters; the size becomes min(1024, MAX_WIDTH) x 1024.
`default_nettype none

module gradient_magnitude_forward_diff #(
   parameter int MAX_WIDTH = gmfd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gmfd_req_if.sink                            req_bus,
   gmfd_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [gmfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gmfd_pkg::CSR_W-1:0]     csr_wdata
);
   import gmfd_pkg::*;

   gmfd_cmd_type    cmd;
   gmfd_status_type status;
   logic            req_ready;

   gmfd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   gmfd_dp #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .pixel            (req_bus.pixel),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_grad_h       (rsp_bus.grad_h),
      .rsp_grad_v       (rsp_bus.grad_v),
      .rsp_magnitude    (rsp_bus.magnitude),
      .rsp_col          (rsp_bus.col),
      .rsp_row          (rsp_bus.row),
      .rsp_last_of_frame(rsp_bus.last_of_frame)
   );

   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire
